FILE: src/ddmm_pkg.sv
// ----------------------------------------------------------------------------
// ddmm_pkg
// Shared constants, field types and tables for the dddmm.mmmm to decimal
// degrees converter.
// ----------------------------------------------------------------------------
package ddmm_pkg;

	// Largest number of digits before the dot, and fraction digits kept.
	localparam int INT_DIGITS  = 5;
	localparam int FRAC_DIGITS = 5;

	// Character codes.
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_DOT  = 8'h2E;

	// Field widths.
	localparam int CH_W      = 8;
	localparam int POS_W     = 34;
	localparam int ICNT_W    = 3;
	localparam int DEG_W     = $clog2(10 ** (INT_DIGITS - 2));
	localparam int FCNT_W    = $clog2(FRAC_DIGITS + 1);
	localparam int FRAC_W    = 24;
	localparam int MIN_W     = 30;
	localparam int QTR_W     = MIN_W - 2;
	localparam int RECIP_W   = 29;
	localparam int PROD_W    = QTR_W + RECIP_W;
	localparam int RECIP_SH  = 32;
	localparam int PART_W    = PROD_W - RECIP_SH;
	localparam int DEG_E7_W  = DEG_W + FRAC_W;
	localparam int SUM_W     = (DEG_E7_W + 1 > POS_W + 1) ? DEG_E7_W + 1 : POS_W + 1;

	// Scale of the result and the reciprocal used to divide by fifteen.
	localparam logic [FRAC_W-1:0]  E7       = 24'd10000000;
	localparam logic [RECIP_W-1:0] RECIP15  = 29'd286331154;
	localparam logic [POS_W-1:0]   POS_MAX  = {POS_W{1'b1}};

	// Everything the conversion needs from one finished field.
	typedef struct packed {
		logic [DEG_W-1:0]  deg;
		logic [3:0]        tens;
		logic [3:0]        units;
		logic [FRAC_W-1:0] frac;
		logic              bad;
	} field_t;

	// Weight of a fraction digit at position k, in 1e-7 minute units.
	function automatic logic [FRAC_W-1:0] frac_weight(input logic [2:0] k);
		logic [FRAC_W-1:0] w;
		unique case (k)
			3'd0:    w = 24'd1000000;
			3'd1:    w = 24'd100000;
			3'd2:    w = 24'd10000;
			3'd3:    w = 24'd1000;
			3'd4:    w = 24'd100;
			3'd5:    w = 24'd10;
			3'd6:    w = 24'd1;
			default: w = 24'd0;
		endcase
		return w;
	endfunction

endpackage

FILE: src/ddmm_char_acc.sv
// ----------------------------------------------------------------------------
// ddmm_char_acc
// Per-character field parser: keeps the running degrees, minutes and scaled
// fraction, and presents the finished field on the closing character.
// ----------------------------------------------------------------------------
module ddmm_char_acc
	import ddmm_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [CH_W-1:0] ch,
	input  logic            last,
	output field_t          fin
);

	logic [DEG_W-1:0]  deg_q, deg_n;
	logic [3:0]        tens_q, tens_n;
	logic [3:0]        units_q, units_n;
	logic [ICNT_W-1:0] icnt_q, icnt_n;
	logic              dot_q, dot_n;
	logic [FRAC_W-1:0] frac_q, frac_n;
	logic [FCNT_W-1:0] fcnt_q, fcnt_n;
	logic              stop_q, stop_n;
	logic              bad_q, bad_n;
	logic              is_digit;
	logic [3:0]        digit;

	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign digit    = ch[3:0];

	always_comb begin
		deg_n   = deg_q;
		tens_n  = tens_q;
		units_n = units_q;
		icnt_n  = icnt_q;
		dot_n   = dot_q;
		frac_n  = frac_q;
		fcnt_n  = fcnt_q;
		stop_n  = stop_q;
		bad_n   = bad_q;
		if (!dot_q) begin
			if (ch == CH_DOT) begin
				dot_n = 1'b1;
				if (icnt_q < ICNT_W'(2))
					bad_n = 1'b1;
			end else if (is_digit) begin
				if (icnt_q != {ICNT_W{1'b1}})
					icnt_n = icnt_q + 1'b1;
				if (icnt_n > ICNT_W'(INT_DIGITS)) begin
					bad_n = 1'b1;
				end else begin
					// The last two digits shift through tens and units.
					deg_n   = DEG_W'(deg_q * DEG_W'(10) + DEG_W'(tens_q));
					tens_n  = units_q;
					units_n = digit;
				end
			end else begin
				bad_n = 1'b1;
			end
		end else if (!stop_q) begin
			if (is_digit && (fcnt_q < FCNT_W'(FRAC_DIGITS))) begin
				frac_n = frac_q + FRAC_W'(digit * frac_weight(3'(fcnt_q)));
				fcnt_n = fcnt_q + 1'b1;
			end else begin
				stop_n = 1'b1;
			end
		end
	end

	assign fin.deg   = deg_n;
	assign fin.tens  = tens_n;
	assign fin.units = units_n;
	assign fin.frac  = frac_n;
	assign fin.bad   = bad_n | ~dot_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q   <= '0;
			tens_q  <= '0;
			units_q <= '0;
			icnt_q  <= '0;
			dot_q   <= 1'b0;
			frac_q  <= '0;
			fcnt_q  <= '0;
			stop_q  <= 1'b0;
			bad_q   <= 1'b0;
		end else if (take) begin
			if (last) begin
				deg_q   <= '0;
				tens_q  <= '0;
				units_q <= '0;
				icnt_q  <= '0;
				dot_q   <= 1'b0;
				frac_q  <= '0;
				fcnt_q  <= '0;
				stop_q  <= 1'b0;
				bad_q   <= 1'b0;
			end else begin
				deg_q   <= deg_n;
				tens_q  <= tens_n;
				units_q <= units_n;
				icnt_q  <= icnt_n;
				dot_q   <= dot_n;
				frac_q  <= frac_n;
				fcnt_q  <= fcnt_n;
				stop_q  <= stop_n;
				bad_q   <= bad_n;
			end
		end
	end

endmodule

FILE: src/ddmm_convert.sv
// ----------------------------------------------------------------------------
// ddmm_convert
// Pipelined conversion of a finished field to 1e-7 degree units, with a
// result register on the output side.
// ----------------------------------------------------------------------------
module ddmm_convert
	import ddmm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  field_t           fin,
	output logic             ready,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [POS_W-1:0] res_pos,
	output logic             res_error
);

	field_t               fld_s1;
	logic                 valid_s1, valid_s2, valid_s3, valid_q;
	logic                 ready_s1, ready_s2, ready_s3, ready_q;
	logic [MIN_W-1:0]     min_s2;
	logic [DEG_E7_W-1:0]  deg_e7_s2, deg_e7_s3;
	logic                 bad_s2, bad_s3;
	logic [PROD_W-1:0]    prod_s3;
	logic [6:0]           mm;
	logic [PART_W-1:0]    part;
	logic [SUM_W-1:0]     sum;
	logic [POS_W-1:0]     pos_q;
	logic                 err_q;

	assign ready_q  = ~valid_q | ~res_stall;
	assign ready_s3 = ~valid_s3 | ready_q;
	assign ready_s2 = ~valid_s2 | ready_s3;
	assign ready_s1 = ~valid_s1 | ready_s2;
	assign ready    = ready_s1;

	assign mm   = 7'(fld_s1.tens * 7'd10 + 7'(fld_s1.units));
	assign part = prod_s3[PROD_W-1:RECIP_SH];
	assign sum  = SUM_W'(deg_e7_s3) + SUM_W'(part);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= load;
			if (ready_s2)
				valid_s2 <= valid_s1;
			if (ready_s3)
				valid_s3 <= valid_s2;
			if (ready_q)
				valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && load)
			fld_s1 <= fin;
		if (ready_s2 && valid_s1) begin
			min_s2    <= MIN_W'(mm) * MIN_W'(E7) + MIN_W'(fld_s1.frac);
			deg_e7_s2 <= DEG_E7_W'(fld_s1.deg) * DEG_E7_W'(E7);
			bad_s2    <= fld_s1.bad;
		end
		if (ready_s3 && valid_s2) begin
			// Minutes over sixty: a quarter, then over fifteen by reciprocal.
			prod_s3   <= PROD_W'(min_s2[MIN_W-1:2]) * PROD_W'(RECIP15);
			deg_e7_s3 <= deg_e7_s2;
			bad_s3    <= bad_s2;
		end
		if (ready_q && valid_s3) begin
			err_q <= bad_s3;
			if (bad_s3)
				pos_q <= '0;
			else if (sum > SUM_W'(POS_MAX))
				pos_q <= POS_MAX;
			else
				pos_q <= POS_W'(sum);
		end
	end

	assign res_valid = valid_q;
	assign res_pos   = pos_q;
	assign res_error = err_q;

endmodule

FILE: src/ddmm_position_to_degrees_core.sv
// ----------------------------------------------------------------------------
// ddmm_position_to_degrees_core
// Converts a latitude or longitude field in dddmm.mmmm form, one character
// per transfer, into unsigned decimal degrees in units of 1e-7 degree.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   input    in         in_valid / in_stall  ch[7:0], last
//   result   out        out_valid/ out_stall position_e7[33:0], error
//
// One character is taken per cycle when nothing is held up downstream.
// The result for a field passes through stages s1, s2 and s3 into the result
// register, which presents it, after the transfer of its final character;
// the multiplier stages make up that path.
// Reset clears the parser state and all pipeline valid flags.
// A stalled result holds; characters still flow while any pipeline stage
// behind the result register is empty.
//
module ddmm_position_to_degrees_core
	import ddmm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [CH_W-1:0]  ch,
	input  logic             last,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [POS_W-1:0] position_e7,
	output logic             error
);

	// A character transfer happens whenever the first conversion stage can
	// take a finished field, so the parser never runs ahead of the pipeline.
	logic   conv_ready;
	logic   accept;
	field_t fin;

	assign in_stall = ~conv_ready;
	assign accept   = in_valid & conv_ready;

	// Character parser: running digits, dot handling and error tracking.
	ddmm_char_acc u_char_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (accept),
		.ch     (ch),
		.last   (last),
		.fin    (fin)
	);

	// Arithmetic back end: scaling, division by sixty, saturation and the
	// result register.
	ddmm_convert u_convert (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept & last),
		.fin       (fin),
		.ready     (conv_ready),
		.res_valid (out_valid),
		.res_stall (out_stall),
		.res_pos   (position_e7),
		.res_error (error)
	);

endmodule
